@@ rtl/core/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
// Request and status codes, cell command type and controller states.
// No dependencies.
package ple_pkg;

  // Width of the fixed payload fields.
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_BACK  = 3'd1,
    REQ_INS_POS   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_BACK  = 3'd4,
    REQ_DEL_POS   = 3'd5,
    REQ_LIST      = 3'd6
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_t;

  // Command broadcast to every cell of the chain. Cell indices never exceed
  // the range of the position field, so they share its width.
  typedef struct packed {
    cell_op_t                   op;
    logic [POS_W-1:0]           idx;
    logic [POS_W-1:0]           last;
    logic signed [VALUE_W-1:0]  value;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } ctrl_state_t;

endpackage

@@ rtl/core/ple_req_if.sv @@
// Request channel of the positional list engine: valid, ready and payload.
// Depends on ple_pkg for field widths.
interface ple_req_if;
  import ple_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [2:0]                req_type;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, req_type, position, item_value, input ready);
  modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

@@ rtl/core/ple_rsp_if.sv @@
// Result channel of the positional list engine: valid, ready and payload.
// Depends on ple_pkg for field widths.
interface ple_rsp_if;
  import ple_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] result_value;
  logic                      run_end;

  modport source (output valid, status, result_value, run_end, input ready);
  modport sink   (input valid, status, result_value, run_end, output ready);
endinterface

@@ rtl/core/ple_cell.sv @@
// One storage cell of the list chain, holding a single entry.
// Depends on ple_pkg for the cell command type.
module ple_cell
  import ple_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic signed [VALUE_W-1:0] right_value,
  input  logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] value
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (MY_IDX == cmd.idx) begin
          value <= cmd.value;
        end else if (MY_IDX > cmd.idx) begin
          value <= left_value;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= cmd.idx) begin
          value <= right_value;
        end
      end
      CELL_ROTATE: begin
        // The front entry wraps around to the tail of the occupied cells.
        if (MY_IDX == cmd.last) begin
          value <= front_value;
        end else if (MY_IDX < cmd.last) begin
          value <= right_value;
        end
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Top level of the positional list engine: controller, output register and
// the chain of ple_cell instances. Depends on ple_pkg, ple_req_if, ple_rsp_if.
//
//  Channel | Modport | Payload                            | Moves
//  --------+---------+------------------------------------+---------------------
//  req     | sink    | req_type, position, item_value     | one request
//  rsp     | source  | status, result_value, run_end      | one result item
//
// In an insert or delete every cell shifts toward or away from its neighbor in
// the same edge, so the position does not change the timing. A listing
// accepts the request, then gives one result item per entry. The chain rotates
// by one cell per result item and is back in its original order at the end.
// Reset (rst, synchronous) empties the list; cell contents are not cleared.
// A stalled result holds in the output register; new requests wait until it
// is taken, and a listing pauses its rotation while the output is stalled.
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input logic     clk,
  input logic     rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Common width for comparing a position against the entry count.
  localparam int CMP_W = POS_W + 1;

  // Entry count and listing progress.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] list_idx;
  logic [IDX_W-1:0] list_idx_next;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // Output register.
  logic                      out_valid;
  logic [1:0]                out_status;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_end;

  logic                      load;
  logic [1:0]                load_status;
  logic signed [VALUE_W-1:0] load_value;
  logic                      load_end;

  cell_cmd_t                 cmd;
  logic signed [VALUE_W-1:0] cell_value [CAPACITY];

  logic             slot_free;
  logic             accept;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [POS_W-1:0] pos_idx;
  logic [POS_W-1:0] tail_idx;
  logic [POS_W-1:0] back_idx;
  logic             list_last;

  // The output slot is free when empty or being emptied in this cycle.
  assign slot_free = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign pos_ext  = CMP_W'(req.position);
  assign cnt_ext  = CMP_W'(count);
  assign pos_idx  = req.position - POS_W'(1);
  // Index of the last occupied cell, and of the first free one.
  assign tail_idx = POS_W'(count - CNT_W'(1));
  assign back_idx = POS_W'(count);
  assign list_last = (CNT_W'(list_idx) == count - CNT_W'(1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req.req_type == REQ_LIST && !empty) begin
          state_next = ST_LIST;
        end
      end
      ST_LIST: begin
        if (slot_free && list_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller: handshake, cell command and result loading.
  always_comb begin
    req.ready     = 1'b0;
    cmd.op        = CELL_HOLD;
    cmd.idx       = '0;
    cmd.last      = tail_idx;
    cmd.value     = req.item_value;
    count_next    = count;
    list_idx_next = list_idx;
    load          = 1'b0;
    load_status   = STAT_OK;
    load_value    = '0;
    load_end      = 1'b1;
    case (state)
      ST_IDLE: begin
        req.ready = slot_free;
        if (accept) begin
          case (req.req_type)
            REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
              load = 1'b1;
              if (full) begin
                load_status = STAT_FULL;
              end else if (req.req_type == REQ_INS_POS &&
                           (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))) begin
                load_status = STAT_RANGE;
              end else begin
                cmd.op     = CELL_INSERT;
                count_next = count + CNT_W'(1);
                if (req.req_type == REQ_INS_FRONT) begin
                  cmd.idx = '0;
                end else if (req.req_type == REQ_INS_BACK) begin
                  cmd.idx = back_idx;
                end else begin
                  cmd.idx = pos_idx;
                end
              end
            end
            REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
              load = 1'b1;
              if (req.req_type == REQ_DEL_FRONT) begin
                cmd.idx = '0;
              end else if (req.req_type == REQ_DEL_BACK) begin
                cmd.idx = tail_idx;
              end else begin
                cmd.idx = pos_idx;
              end
              if (empty) begin
                load_status = STAT_EMPTY;
              end else if (req.req_type == REQ_DEL_POS &&
                           (pos_ext == '0 || pos_ext > cnt_ext)) begin
                load_status = STAT_RANGE;
              end else begin
                // The removed entry is read before the chain closes the gap.
                cmd.op     = CELL_DELETE;
                count_next = count - CNT_W'(1);
                load_value = cell_value[cmd.idx[IDX_W-1:0]];
              end
            end
            REQ_LIST: begin
              if (empty) begin
                load        = 1'b1;
                load_status = STAT_EMPTY;
              end else begin
                list_idx_next = '0;
              end
            end
            default: begin
              // Unused request code: accepted and dropped without a result.
            end
          endcase
        end
      end
      ST_LIST: begin
        if (slot_free) begin
          load          = 1'b1;
          load_value    = cell_value[0];
          load_end      = list_last;
          cmd.op        = CELL_ROTATE;
          list_idx_next = list_idx + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      list_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= load_status;
      out_value  <= load_value;
      out_end    <= load_end;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.result_value = out_value;
  assign rsp.run_end      = out_end;

  // Chain of cells; cell 0 holds the front of the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_value = req.item_value;
    end else begin : g_inner_l
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right_value = cell_value[i];
    end else begin : g_inner_r
      assign right_value = cell_value[i+1];
    end

    ple_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_value (left_value),
      .right_value(right_value),
      .front_value(cell_value[0]),
      .value      (cell_value[i])
    );
  end

endmodule
